// ===== design/quaternion_pose_amplifier_assert.svh =====
// ----------------------------------------------------------------------------
// quaternion_pose_amplifier_assert.svh
// Assertion macros used by the pose amplifier checker.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_POSE_AMPLIFIER_ASSERT_SVH
`define QUATERNION_POSE_AMPLIFIER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define QPA_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define QPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/qpa_pkg.sv =====
// ----------------------------------------------------------------------------
// qpa_pkg
// Types and constants of the quaternion pose amplifier.
// ----------------------------------------------------------------------------
package qpa_pkg;

  localparam int JOINT_SLOTS = 16;
  localparam int JOINT_IDX_W = (JOINT_SLOTS > 1) ? $clog2(JOINT_SLOTS) : 1;

  localparam logic CMD_STORE   = 1'b0;
  localparam logic CMD_AMPLIFY = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam int SQRT_STEPS      = 28;
  localparam int CORDIC_STEPS    = 28;
  localparam int DIV_STEPS       = 32;
  localparam int AXIS_ZERO_LIMIT = 281;

  localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sd652032874;

  localparam logic signed [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81,
    32'sd41,        32'sd20,        32'sd10,        32'sd5
  };

  typedef struct packed {
    logic               cmd;
    logic [3:0]         joint;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic signed [15:0] rot_w;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        turn_gain;
    logic [15:0]        slide_gain;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         joint_out;
    logic signed [15:0] out_rot_x;
    logic signed [15:0] out_rot_y;
    logic signed [15:0] out_rot_z;
    logic signed [15:0] out_rot_w;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
  } out_item_t;

  // element 0 is x, 3 is w
  typedef struct packed {
    logic [3:0]       joint;
    logic [3:0][15:0] now_rot;
    logic [3:0][15:0] rest_rot;
    logic [2:0][31:0] now_pos;
    logic [2:0][31:0] rest_pos;
    logic [15:0]      turn_gain;
    logic [15:0]      slide_gain;
  } work_t;

endpackage

// ===== design/quaternion_pose_amplifier.sv =====
// Amplify transactions pass through the back-end pipeline to the result ports;
// a store transaction updates the rest table at once, no result.
// Throughput: one transaction per cycle unless the output buffer is full, set
// by the fully pipelined square root, CORDIC and divider stages of the back end.
// Reset: rst (synchronous) empties the queue, pipeline and output buffer; the
// rest table is not cleared.
// ----------------------------------------------------------------------------
// quaternion_pose_amplifier
// Rest pose table with rotation and translation amplification.
// ----------------------------------------------------------------------------
module quaternion_pose_amplifier import qpa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  item,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  logic  q_full;
  logic  q_wr;
  work_t q_wdata;
  logic  q_rd;
  work_t q_rdata;
  logic  q_valid;

  qpa_front u_front (
    .clk    (clk),
    .push   (push),
    .item   (item),
    .full   (full),
    .q_full (q_full),
    .q_wr   (q_wr),
    .q_data (q_wdata)
  );

  qpa_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .valid (q_valid)
  );

  qpa_back u_back (
    .clk    (clk),
    .rst    (rst),
    .wdata  (q_rdata),
    .wvalid (q_valid),
    .wtake  (q_rd),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

// ===== design/qpa_front.sv =====
// ----------------------------------------------------------------------------
// qpa_front
// Accepts items, keeps the rest pose table, forwards amplify work.
// ----------------------------------------------------------------------------
module qpa_front import qpa_pkg::*; (
  input  logic     clk,
  input  logic     push,
  input  in_item_t item,
  output logic     full,
  input  logic     q_full,
  output logic     q_wr,
  output work_t    q_data
);

  logic [63:0] rest_rotation    [JOINT_SLOTS];
  logic [63:0] rest_position_xy [JOINT_SLOTS];
  logic [31:0] rest_position_z  [JOINT_SLOTS];

  logic                   accept;
  logic                   in_range;
  logic [JOINT_IDX_W-1:0] idx;

  assign full     = q_full;
  assign accept   = push & ~q_full;
  assign in_range = 32'(item.joint) < JOINT_SLOTS;
  assign idx      = JOINT_IDX_W'(item.joint);

  always_ff @(posedge clk) begin
    if (accept && in_range && item.cmd == CMD_STORE) begin
      rest_rotation[idx]    <= {item.rot_w, item.rot_z, item.rot_y, item.rot_x};
      rest_position_xy[idx] <= {item.pos_y, item.pos_x};
      rest_position_z[idx]  <= item.pos_z;
    end
  end

  assign q_wr = accept && in_range && item.cmd == CMD_AMPLIFY;

  always_comb begin
    q_data.joint      = item.joint;
    q_data.now_rot    = {item.rot_w, item.rot_z, item.rot_y, item.rot_x};
    q_data.rest_rot   = rest_rotation[idx];
    q_data.now_pos    = {item.pos_z, item.pos_y, item.pos_x};
    q_data.rest_pos   = {rest_position_z[idx], rest_position_xy[idx]};
    q_data.turn_gain  = item.turn_gain;
    q_data.slide_gain = item.slide_gain;
  end

endmodule

// ===== design/qpa_queue.sv =====
// ----------------------------------------------------------------------------
// qpa_queue
// Short queue of amplify work between front and back.
// ----------------------------------------------------------------------------
module qpa_queue import qpa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  work_t wdata,
  output logic  full,
  input  logic  rd,
  output work_t rdata,
  output logic  valid
);

  work_t                  mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wptr;
  logic [QUEUE_PTR_W-1:0] rptr;
  logic [QUEUE_PTR_W:0]   count;

  assign full  = count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
  assign valid = count != '0;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/qpa_back.sv =====
// ----------------------------------------------------------------------------
// qpa_back
// Amplification pipeline: difference quaternion, square root, CORDIC angle,
// gain, CORDIC sine and cosine, axis division, recombination, output buffer.
// ----------------------------------------------------------------------------
module qpa_back import qpa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  work_t     wdata,
  input  logic      wvalid,
  output logic      wtake,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  typedef struct packed {
    logic [3:0]       joint;
    logic [3:0][15:0] now_rot;
    logic [3:0][15:0] rest_rot;
    logic [2:0][31:0] pos;
    logic [15:0]      turn_gain;
    logic             zero;
    logic [2:0][27:0] dxyz;
    logic [27:0]      dw;
    logic [27:0]      s;
    logic [1:0]       quad;
    logic [33:0]      cs;
  } side_t;

  function automatic logic [15:0] sat16(input logic signed [52:0] v);
    if (v > 53'sd32767) begin
      return 16'h7fff;
    end else if (v < -53'sd32768) begin
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [50:0] v);
    if (v > 51'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (v < -51'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  logic adv;
  logic fin_v;
  out_item_t fin;

  // ---------------- stage A: difference quaternion ----------------
  logic signed [16:0] qa [4];
  logic signed [16:0] qb [4];
  logic               a_v;
  work_t              a_w;
  logic signed [34:0] a_d  [4];
  logic signed [32:0] a_dp [3];

  assign wtake = adv & wvalid;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qa[i] = -{wdata.rest_rot[i][15], wdata.rest_rot[i]};
    end
    qa[3] = $signed({wdata.rest_rot[3][15], wdata.rest_rot[3]});
    for (int i = 0; i < 4; i++) begin
      qb[i] = $signed({wdata.now_rot[i][15], wdata.now_rot[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_w    <= wdata;
      a_d[0] <= qa[3] * qb[0] + qa[0] * qb[3] + qa[1] * qb[2] - qa[2] * qb[1];
      a_d[1] <= qa[3] * qb[1] - qa[0] * qb[2] + qa[1] * qb[3] + qa[2] * qb[0];
      a_d[2] <= qa[3] * qb[2] + qa[0] * qb[1] - qa[1] * qb[0] + qa[2] * qb[3];
      a_d[3] <= qa[3] * qb[3] - qa[0] * qb[0] - qa[1] * qb[1] - qa[2] * qb[2];
      for (int i = 0; i < 3; i++) begin
        a_dp[i] <= $signed({wdata.now_pos[i][31], wdata.now_pos[i]}) -
                   $signed({wdata.rest_pos[i][31], wdata.rest_pos[i]});
      end
    end
  end

  // ---------------- stage B: hemisphere flip, rounding ----------------
  logic signed [35:0] fl [4];
  logic signed [35:0] rn [4];
  logic               b_v;
  work_t              b_w;
  logic signed [27:0] b_d  [4];
  logic signed [49:0] b_tp [3];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      fl[i] = a_d[3][34] ? -36'(a_d[i]) : 36'(a_d[i]);
      rn[i] = (fl[i] + 36'sd32) >>> 6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_w <= a_w;
      for (int i = 0; i < 4; i++) begin
        b_d[i] <= rn[i][27:0];
      end
      for (int i = 0; i < 3; i++) begin
        b_tp[i] <= a_dp[i] * $signed({1'b0, a_w.slide_gain});
      end
    end
  end

  // ---------------- stage C: squares, translation ----------------
  logic signed [55:0] sqv [3];
  logic signed [50:0] pr  [3];
  logic               c_v;
  logic [55:0]        c_sq [3];
  side_t              c_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqv[i] = b_d[i] * b_d[i];
      pr[i]  = $signed({b_w.rest_pos[i][31], b_w.rest_pos[i]}) +
               ((b_tp[i] + 50'sd2048) >>> 12);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        c_sq[i]             <= sqv[i];
        c_side.pos[i]       <= sat32(pr[i]);
        c_side.dxyz[i]      <= b_d[i];
      end
      c_side.joint     <= b_w.joint;
      c_side.now_rot   <= b_w.now_rot;
      c_side.rest_rot  <= b_w.rest_rot;
      c_side.turn_gain <= b_w.turn_gain;
      c_side.zero      <= 1'b0;
      c_side.dw        <= b_d[3];
      c_side.s         <= '0;
      c_side.quad      <= '0;
      c_side.cs        <= '0;
    end
  end

  // ---------------- stage D and square root chain ----------------
  logic [55:0]     s2;
  side_t           sq_in;
  logic [SQRT_STEPS:0] sq_v;
  logic [55:0]     sq_n [SQRT_STEPS+1];
  logic [55:0]     sq_r [SQRT_STEPS+1];
  side_t           sq_side [SQRT_STEPS+1];

  assign s2 = c_sq[0] + c_sq[1] + c_sq[2];

  always_comb begin
    sq_in      = c_side;
    sq_in.zero = s2 <= 56'(AXIS_ZERO_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_n[0]    <= s2;
      sq_r[0]    <= '0;
      sq_side[0] <= sq_in;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [55:0] BITV = 56'd1 << (2 * (SQRT_STEPS - 1 - k));
    logic [56:0] trial;

    assign trial = {1'b0, sq_r[k]} + {1'b0, BITV};

    always_ff @(posedge clk) begin
      if (adv) begin
        if ({1'b0, sq_n[k]} >= trial) begin
          sq_n[k+1] <= sq_n[k] - trial[55:0];
          sq_r[k+1] <= (sq_r[k] >> 1) + BITV;
        end else begin
          sq_n[k+1] <= sq_n[k];
          sq_r[k+1] <= sq_r[k] >> 1;
        end
        sq_side[k+1] <= sq_side[k];
      end
    end
  end

  // ---------------- stage E and vectoring CORDIC ----------------
  side_t                 vc_in;
  logic [CORDIC_STEPS:0] vc_v;
  logic signed [31:0]    vc_x [CORDIC_STEPS+1];
  logic signed [31:0]    vc_y [CORDIC_STEPS+1];
  logic signed [31:0]    vc_z [CORDIC_STEPS+1];
  side_t                 vc_side [CORDIC_STEPS+1];

  always_comb begin
    vc_in   = sq_side[SQRT_STEPS];
    vc_in.s = sq_r[SQRT_STEPS][27:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vc_x[0]    <= 32'($signed(sq_side[SQRT_STEPS].dw));
      vc_y[0]    <= {4'd0, sq_r[SQRT_STEPS][27:0]};
      vc_z[0]    <= '0;
      vc_side[0] <= vc_in;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
    logic signed [31:0] xs;
    logic signed [31:0] ys;

    assign xs = vc_x[k] >>> k;
    assign ys = vc_y[k] >>> k;

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!vc_y[k][31]) begin
          vc_x[k+1] <= vc_x[k] + ys;
          vc_y[k+1] <= vc_y[k] - xs;
          vc_z[k+1] <= vc_z[k] + ATAN_TURNS[k];
        end else begin
          vc_x[k+1] <= vc_x[k] - ys;
          vc_y[k+1] <= vc_y[k] + xs;
          vc_z[k+1] <= vc_z[k] - ATAN_TURNS[k];
        end
        vc_side[k+1] <= vc_side[k];
      end
    end
  end

  // ---------------- stage F: gain ----------------
  logic               f_v;
  logic signed [48:0] f_p;
  side_t              f_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      f_p    <= vc_z[CORDIC_STEPS] * $signed({1'b0, vc_side[CORDIC_STEPS].turn_gain});
      f_side <= vc_side[CORDIC_STEPS];
    end
  end

  // ---------------- stage G and rotation CORDIC ----------------
  logic signed [48:0]    hr;
  logic [31:0]           theta;
  logic [31:0]           qsum;
  logic [1:0]            quad;
  logic [31:0]           red;
  side_t                 rc_in;
  logic [CORDIC_STEPS:0] rc_v;
  logic signed [33:0]    rc_x [CORDIC_STEPS+1];
  logic signed [33:0]    rc_y [CORDIC_STEPS+1];
  logic signed [33:0]    rc_z [CORDIC_STEPS+1];
  side_t                 rc_side [CORDIC_STEPS+1];

  always_comb begin
    hr    = (f_p + 49'sd2048) >>> 12;
    theta = hr[31:0];
    qsum  = theta + 32'h2000_0000;
    quad  = qsum[31:30];
    red   = theta - {quad, 30'd0};
  end

  always_comb begin
    rc_in      = f_side;
    rc_in.quad = quad;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rc_x[0]    <= CORDIC_INV_GAIN;
      rc_y[0]    <= '0;
      rc_z[0]    <= 34'($signed(red));
      rc_side[0] <= rc_in;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
    logic signed [33:0] xs;
    logic signed [33:0] ys;

    assign xs = rc_x[k] >>> k;
    assign ys = rc_y[k] >>> k;

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!rc_z[k][33]) begin
          rc_x[k+1] <= rc_x[k] - ys;
          rc_y[k+1] <= rc_y[k] + xs;
          rc_z[k+1] <= rc_z[k] - ATAN_TURNS[k];
        end else begin
          rc_x[k+1] <= rc_x[k] + ys;
          rc_y[k+1] <= rc_y[k] - xs;
          rc_z[k+1] <= rc_z[k] + ATAN_TURNS[k];
        end
        rc_side[k+1] <= rc_side[k];
      end
    end
  end

  // ---------------- stage H: quadrant map ----------------
  logic signed [33:0] mx;
  logic signed [33:0] my;
  logic signed [33:0] mc;
  logic signed [33:0] ms;
  side_t              h_in;
  logic               h_v;
  logic signed [33:0] h_s;
  side_t              h_side;

  always_comb begin
    mx = rc_x[CORDIC_STEPS];
    my = rc_y[CORDIC_STEPS];
    case (rc_side[CORDIC_STEPS].quad)
      2'd0: begin
        mc = mx;
        ms = my;
      end
      2'd1: begin
        mc = -my;
        ms = mx;
      end
      2'd2: begin
        mc = -mx;
        ms = -my;
      end
      default: begin
        mc = my;
        ms = -mx;
      end
    endcase
  end

  always_comb begin
    h_in    = rc_side[CORDIC_STEPS];
    h_in.cs = mc;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_s    <= ms;
      h_side <= h_in;
    end
  end

  // ---------------- stage I: numerators ----------------
  logic               i_v;
  logic signed [61:0] i_num [3];
  side_t              i_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        i_num[i] <= $signed(h_side.dxyz[i]) * h_s;
      end
      i_side <= h_side;
    end
  end

  // ---------------- stage J and division chain ----------------
  logic [61:0]        mag [3];
  logic [DIV_STEPS:0] dv_v;
  logic [29:0]        dv_rem [DIV_STEPS+1][3];
  logic [31:0]        dv_low [DIV_STEPS+1][3];
  logic [2:0]         dv_neg [DIV_STEPS+1];
  side_t              dv_side [DIV_STEPS+1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = i_num[i][61] ? 62'(-i_num[i]) : 62'(i_num[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= mag[i][61:32];
        dv_low[0][i] <= mag[i][31:0];
        dv_neg[0][i] <= i_num[i][61];
      end
      dv_side[0] <= i_side;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [30:0] t  [3];
    logic [2:0]  ge;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]  = {dv_rem[k][i], dv_low[k][i][31]};
        ge[i] = t[i] >= {3'd0, dv_side[k].s};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem[k+1][i] <= ge[i] ? 30'(t[i] - {3'd0, dv_side[k].s}) : t[i][29:0];
          dv_low[k+1][i] <= {dv_low[k][i][30:0], ge[i]};
        end
        dv_neg[k+1]  <= dv_neg[k];
        dv_side[k+1] <= dv_side[k];
      end
    end
  end

  // ---------------- stage K: quotient sign ----------------
  logic               k_v;
  logic signed [32:0] k_big [3];
  side_t              k_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        k_big[i] <= dv_neg[DIV_STEPS][i] ? -$signed({1'b0, dv_low[DIV_STEPS][i]}) :
                                            $signed({1'b0, dv_low[DIV_STEPS][i]});
      end
      k_side <= dv_side[DIV_STEPS];
    end
  end

  // ---------------- stage L: rest times scaled difference ----------------
  logic signed [15:0] ra [4];
  logic signed [33:0] bb [4];
  logic               l_v;
  logic signed [52:0] l_o [4];
  side_t              l_side;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ra[i] = $signed(k_side.rest_rot[i]);
    end
    for (int i = 0; i < 3; i++) begin
      bb[i] = 34'(k_big[i]);
    end
    bb[3] = $signed(k_side.cs);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l_o[0] <= ra[3] * bb[0] + ra[0] * bb[3] + ra[1] * bb[2] - ra[2] * bb[1];
      l_o[1] <= ra[3] * bb[1] - ra[0] * bb[2] + ra[1] * bb[3] + ra[2] * bb[0];
      l_o[2] <= ra[3] * bb[2] + ra[0] * bb[1] - ra[1] * bb[0] + ra[2] * bb[3];
      l_o[3] <= ra[3] * bb[3] - ra[0] * bb[0] - ra[1] * bb[1] - ra[2] * bb[2];
      l_side <= k_side;
    end
  end

  // ---------------- stage M: round, saturate, select ----------------
  logic [15:0] orot [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      orot[i] = l_side.zero ? l_side.now_rot[i] :
                              sat16((l_o[i] + 53'sd536870912) >>> 30);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin.joint_out <= l_side.joint;
      fin.out_rot_x <= orot[0];
      fin.out_rot_y <= orot[1];
      fin.out_rot_z <= orot[2];
      fin.out_rot_w <= orot[3];
      fin.out_pos_x <= l_side.pos[0];
      fin.out_pos_y <= l_side.pos[1];
      fin.out_pos_z <= l_side.pos[2];
    end
  end

  // ---------------- valid chain ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v   <= 1'b0;
      b_v   <= 1'b0;
      c_v   <= 1'b0;
      sq_v  <= '0;
      vc_v  <= '0;
      f_v   <= 1'b0;
      rc_v  <= '0;
      h_v   <= 1'b0;
      i_v   <= 1'b0;
      dv_v  <= '0;
      k_v   <= 1'b0;
      l_v   <= 1'b0;
      fin_v <= 1'b0;
    end else if (adv) begin
      a_v   <= wvalid;
      b_v   <= a_v;
      c_v   <= b_v;
      sq_v  <= {sq_v[SQRT_STEPS-1:0], c_v};
      vc_v  <= {vc_v[CORDIC_STEPS-1:0], sq_v[SQRT_STEPS]};
      f_v   <= vc_v[CORDIC_STEPS];
      rc_v  <= {rc_v[CORDIC_STEPS-1:0], f_v};
      h_v   <= rc_v[CORDIC_STEPS];
      i_v   <= h_v;
      dv_v  <= {dv_v[DIV_STEPS-1:0], i_v};
      k_v   <= dv_v[DIV_STEPS];
      l_v   <= k_v;
      fin_v <= l_v;
    end
  end

  // ---------------- output buffer ----------------
  out_item_t  obuf [2];
  logic [1:0] ocnt;
  logic       owp;
  logic       orp;
  logic       opush;
  logic       opop;

  assign adv    = ocnt != 2'd2;
  assign opush  = adv & fin_v;
  assign empty  = ocnt == 2'd0;
  assign opop   = pop & ~empty;
  assign result = obuf[orp];

  always_ff @(posedge clk) begin
    if (opush) begin
      obuf[owp] <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= '0;
      owp  <= 1'b0;
      orp  <= 1'b0;
    end else begin
      if (opush) begin
        owp <= ~owp;
      end
      if (opop) begin
        orp <= ~orp;
      end
      if (opush && !opop) begin
        ocnt <= ocnt + 1'b1;
      end else if (opop && !opush) begin
        ocnt <= ocnt - 1'b1;
      end
    end
  end

endmodule

// ===== design/qpa_checker.sv =====
// ----------------------------------------------------------------------------
// qpa_checker
// Port-level checks of the pose amplifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "quaternion_pose_amplifier_assert.svh"

module qpa_checker import qpa_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      push,
  input logic      full,
  input in_item_t  item,
  input logic      empty,
  input logic      pop,
  input out_item_t result
);

  logic [15:0] outstanding;
  logic        amp_in;
  logic        res_out;

  assign amp_in  = push && !full && item.cmd == CMD_AMPLIFY;
  assign res_out = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (amp_in && !res_out) begin
      outstanding <= outstanding + 1'b1;
    end else if (res_out && !amp_in) begin
      outstanding <= outstanding - 1'b1;
    end
  end

  `QPA_ASSERT_IMPLY(a_empty_after_rst, $past(rst), empty, "result pending after reset")
  `QPA_ASSERT_IMPLY(a_ready_after_rst, $past(rst), !full, "full right after reset")
  `QPA_ASSERT_IMPLY(a_no_phantom, !empty, outstanding != 16'd0, "result without amplify")
  `QPA_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(result), "result not held")

endmodule

bind quaternion_pose_amplifier qpa_checker u_chk (.*);

// ===== dv/tb_quaternion_pose_amplifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_pose_amplifier
// Self-checking bench for the rest pose amplifier: stores and amplifies poses,
// predicts every result with a bit-exact fixed-point model, checks in order.
// ----------------------------------------------------------------------------
module tb_quaternion_pose_amplifier;
  import qpa_pkg::*;

  localparam int N_RANDOM = 1230;

  logic      clk;
  logic      rst;
  logic      push;
  logic      full;
  in_item_t  item;
  logic      empty;
  logic      pop;
  out_item_t result;

  int  n_errors;
  int  n_pushed;
  int  n_checked;
  int  n_amplify;
  int  n_zero_axis;
  bit  hold_pop;
  bit  idle_free;
  bit  written [JOINT_SLOTS];

  quaternion_pose_amplifier u_top (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    n_errors++;
  endtask

  function automatic longint asr(input longint v, input int n);
    return v >>> n;
  endfunction

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint isqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic void qmul(output longint o[4], input longint a[4], input longint b[4]);
    o[0] = a[3]*b[0] + a[0]*b[3] + a[1]*b[2] - a[2]*b[1];
    o[1] = a[3]*b[1] - a[0]*b[2] + a[1]*b[3] + a[2]*b[0];
    o[2] = a[3]*b[2] + a[0]*b[1] - a[1]*b[0] + a[2]*b[3];
    o[3] = a[3]*b[3] - a[0]*b[0] - a[1]*b[1] - a[2]*b[2];
  endfunction

  function automatic longint vector_angle(input longint y, input longint x);
    longint z, xs, ys;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = asr(x, i);
      ys = asr(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += longint'(ATAN_TURNS[i]);
      end else begin
        x -= ys; y += xs; z -= longint'(ATAN_TURNS[i]);
      end
    end
    return z;
  endfunction

  function automatic void rotate_angle(input logic [31:0] theta, output longint c,
                                       output longint s);
    logic [31:0] q, r;
    longint z, x, y, xs, ys;
    q = ((theta + 32'h2000_0000) >> 30) & 32'd3;
    r = theta - (q << 30);
    z = longint'($signed(r));
    x = longint'(CORDIC_INV_GAIN);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = asr(x, i);
      ys = asr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(ATAN_TURNS[i]);
      end else begin
        x += ys; y -= xs; z += longint'(ATAN_TURNS[i]);
      end
    end
    case (q)
      0: begin c = x; s = y; end
      1: begin c = -y; s = x; end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  class pose_scoreboard;
    logic [3:0][15:0] rest_rot [JOINT_SLOTS];
    logic [2:0][31:0] rest_pos [JOINT_SLOTS];
    out_item_t        pending [$];
    int               zero_axis;

    function void note_item(input in_item_t t);
      longint now[4], rest[4], inv[4], d[4], o[4], big[4], cs, sn, s, a, p, nowp, rp;
      longint unsigned s2;
      logic [31:0] half;
      out_item_t e;
      if (t.cmd == CMD_STORE) begin
        rest_rot[t.joint] = {t.rot_w, t.rot_z, t.rot_y, t.rot_x};
        rest_pos[t.joint] = {t.pos_z, t.pos_y, t.pos_x};
        return;
      end
      now[0] = t.rot_x; now[1] = t.rot_y; now[2] = t.rot_z; now[3] = t.rot_w;
      for (int i = 0; i < 4; i++) rest[i] = longint'($signed(rest_rot[t.joint][i]));
      inv[0] = -rest[0]; inv[1] = -rest[1]; inv[2] = -rest[2]; inv[3] = rest[3];
      qmul(d, inv, now);
      if (d[3] < 0) for (int i = 0; i < 4; i++) d[i] = -d[i];
      for (int i = 0; i < 4; i++) d[i] = asr(d[i] + 32, 6);
      s2 = longint'(d[0]*d[0]) + longint'(d[1]*d[1]) + longint'(d[2]*d[2]);
      if (s2 > AXIS_ZERO_LIMIT) begin
        s = isqrt(s2);
        a = vector_angle(s, d[3]);
        half = 32'(asr(a * longint'(t.turn_gain) + 2048, 12));
        rotate_angle(half, cs, sn);
        for (int i = 0; i < 3; i++) big[i] = (d[i] * sn) / s;
        big[3] = cs;
        qmul(o, rest, big);
        for (int i = 0; i < 4; i++) o[i] = sat(asr(o[i] + (64'sd1 <<< 29), 30), -32768, 32767);
      end else begin
        for (int i = 0; i < 4; i++) o[i] = now[i];
        zero_axis++;
      end
      e.joint_out = t.joint;
      e.out_rot_x = 16'(o[0]); e.out_rot_y = 16'(o[1]);
      e.out_rot_z = 16'(o[2]); e.out_rot_w = 16'(o[3]);
      for (int i = 0; i < 3; i++) begin
        nowp = (i == 0) ? longint'(t.pos_x) : (i == 1) ? longint'(t.pos_y) : longint'(t.pos_z);
        rp = longint'($signed(rest_pos[t.joint][i]));
        p = sat(rp + asr((nowp - rp) * longint'(t.slide_gain) + 2048, 12),
                -64'sd2147483648, 64'sd2147483647);
        if (i == 0) e.out_pos_x = 32'(p);
        else if (i == 1) e.out_pos_y = 32'(p);
        else e.out_pos_z = 32'(p);
      end
      pending.push_back(e);
    endfunction

    task check_result(input out_item_t r);
      out_item_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected transaction, joint", r.joint_out, -1);
        return;
      end
      e = pending.pop_front();
      if (r.joint_out !== e.joint_out) report_mismatch("joint_out", r.joint_out, e.joint_out);
      if (r.out_rot_x !== e.out_rot_x) report_mismatch("out_rot_x", r.out_rot_x, e.out_rot_x);
      if (r.out_rot_y !== e.out_rot_y) report_mismatch("out_rot_y", r.out_rot_y, e.out_rot_y);
      if (r.out_rot_z !== e.out_rot_z) report_mismatch("out_rot_z", r.out_rot_z, e.out_rot_z);
      if (r.out_rot_w !== e.out_rot_w) report_mismatch("out_rot_w", r.out_rot_w, e.out_rot_w);
      if (r.out_pos_x !== e.out_pos_x) report_mismatch("out_pos_x", r.out_pos_x, e.out_pos_x);
      if (r.out_pos_y !== e.out_pos_y) report_mismatch("out_pos_y", r.out_pos_y, e.out_pos_y);
      if (r.out_pos_z !== e.out_pos_z) report_mismatch("out_pos_z", r.out_pos_z, e.out_pos_z);
    endtask
  endclass

  pose_scoreboard poses;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("timeout at %0t", $time);
    $display("tb_quaternion_pose_amplifier: done, errors");
    $finish;
  end

  // offer one transaction, hold until accepted
  task automatic send(input in_item_t t);
    while (!idle_free && $urandom_range(99) < 38) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= t;
    @(posedge clk);
    while (full) @(posedge clk);
    poses.note_item(t);
    n_pushed++;
    if (t.cmd == CMD_AMPLIFY) n_amplify++;
    if (t.cmd == CMD_STORE) written[t.joint] = 1'b1;
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(200000)) - 32'd100000;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t make_item(input logic c, input logic [3:0] j);
    in_item_t t;
    t.cmd = c; t.joint = j;
    t.rot_x = pick16(); t.rot_y = pick16(); t.rot_z = pick16(); t.rot_w = pick16();
    t.pos_x = pick32(); t.pos_y = pick32(); t.pos_z = pick32();
    t.turn_gain = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(8192));
    t.slide_gain = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(8192));
    return t;
  endfunction

  function automatic logic [3:0] stored_joint();
    logic [3:0] j;
    do j = 4'($urandom); while (!written[j]);
    return j;
  endfunction

  // result side: random idling plus one long hold-off
  initial begin
    pop <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!empty && pop) poses.check_result(result);
      if (!empty && pop) n_checked++;
      pop <= !hold_pop && (idle_free || $urandom_range(99) >= 38);
    end
  end

  initial begin
    in_item_t t;
    poses = new();
    rst <= 1'b1;
    push <= 1'b0;
    item <= '0;
    hold_pop = 1'b0;
    idle_free = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every joint, identity and extremes, zero axis
    for (int j = 0; j < JOINT_SLOTS; j++) begin
      t = make_item(CMD_STORE, 4'(j));
      if (j == 0) begin
        t.rot_x = 0; t.rot_y = 0; t.rot_z = 0; t.rot_w = 16'h7FFF;
        t.pos_x = 32'h7FFF_FFFF; t.pos_y = 32'h8000_0000; t.pos_z = 0;
      end
      send(t);
    end
    t = make_item(CMD_AMPLIFY, 4'd0);
    t.rot_x = 0; t.rot_y = 0; t.rot_z = 0; t.rot_w = 16'h7FFF;
    send(t);
    t.rot_w = 16'h8000; t.turn_gain = 16'hFFFF; t.slide_gain = 16'hFFFF;
    t.pos_x = 32'h8000_0000; t.pos_y = 32'h7FFF_FFFF; t.pos_z = 32'h7FFF_FFFF;
    send(t);
    t = make_item(CMD_AMPLIFY, 4'd1);
    t.rot_x = 16'h7FFF; t.rot_y = 16'h8000; t.turn_gain = 0; t.slide_gain = 0;
    send(t);
    t.turn_gain = 16'hFFFF; t.slide_gain = 16'hFFFF;
    send(t);
    t.rot_x = 16'h8000; t.rot_y = 16'h7FFF; t.turn_gain = 16'h1000;
    send(t);

    // random: mostly amplifies of stored joints, some restores
    for (int k = 0; k < N_RANDOM; k++) begin
      idle_free = (k >= 400 && k < 550);
      if (k == 700) begin
        hold_pop = 1'b1;
        fork
          begin
            repeat (300) @(posedge clk);
            hold_pop = 1'b0;
          end
        join_none
      end
      if ($urandom_range(99) < 25) t = make_item(CMD_STORE, 4'($urandom));
      else t = make_item(CMD_AMPLIFY, stored_joint());
      send(t);
    end
    push <= 1'b0;

    while (poses.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d transactions: %0d amplified, %0d with zero axis, %0d results checked",
             n_pushed, n_amplify, poses.zero_axis, n_checked);
    if (n_errors == 0) begin
      $display("tb_quaternion_pose_amplifier: done, clean");
    end else begin
      $display("tb_quaternion_pose_amplifier: done, errors");
    end
    $finish;
  end

endmodule
